// ===== rtl/core/bcba_pkg.sv =====
// bcba_pkg: shared types and constants for the bitmap contiguous block allocator
// holds the request codes, the sequencer states and the word scan status struct
// no dependencies
`default_nettype none

package bcba_pkg;

    // field widths
    localparam int LEN_W   = 20;   // byte length
    localparam int BSZ_W   = 16;   // block size in bytes
    localparam int BIU_W   = 9;    // blocks in use register
    localparam int START_W = 8;    // start block field
    localparam int NEED_W  = 21;   // unsaturated block count
    localparam int BC_W    = 17;   // reported block count
    localparam int CNT_W   = 9;    // free and used totals
    localparam int CMP_W   = 22;   // common width for index compares

    localparam logic [NEED_W-1:0] BC_MAX = NEED_W'(131071);

    // bitmap word held by one cell
    localparam int WORD_W   = 8;
    localparam int WORD_LOG = 3;
    localparam int POP_W    = 4;

    // register map, decoded on paddr[2]
    localparam logic REG_BLOCK_SIZE    = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        FN_FIND  = 2'd0,
        FN_MARK  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_COUNT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_SCAN = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    // status of one word going past the scan head
    typedef struct packed {
        logic               hit;
        logic [START_W-1:0] hit_start;
        logic [CMP_W-1:0]   run_out;
        logic [POP_W-1:0]   used_cnt;
        logic [POP_W-1:0]   free_cnt;
    } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcba_cell.sv =====
// bcba_cell: one link of the bitmap ring, holds one word of block-used bits
// depends on bcba_pkg
`default_nettype none

module bcba_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift,
    input  wire logic [bcba_pkg::WORD_W-1:0] d,
    output logic      [bcba_pkg::WORD_W-1:0] q
);
    import bcba_pkg::*;

    logic [WORD_W-1:0] word_reg;

    // every block free at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (shift)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcba_divider.sv =====
// bcba_divider: restoring divider, one quotient bit a cycle, rounds up
// depends on bcba_pkg
`default_nettype none

module bcba_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bcba_pkg::LEN_W-1:0] dividend,
    input  wire logic [bcba_pkg::BSZ_W-1:0] divisor,
    output logic                            done,
    output logic      [bcba_pkg::NEED_W-1:0] quotient
);
    import bcba_pkg::*;

    localparam int STEP_W = $clog2(LEN_W);

    logic [BSZ_W:0]    rem_reg;
    logic [LEN_W-1:0]  quo_reg;
    logic [BSZ_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [BSZ_W:0] shifted;
    logic           ge;

    assign shifted = {rem_reg[BSZ_W-1:0], quo_reg[LEN_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            // zero block size acts as one
            dsr_reg <= (divisor == '0) ? BSZ_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, dsr_reg}) : shifted;
            quo_reg <= {quo_reg[LEN_W-2:0], ge};
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(LEN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = NEED_W'(quo_reg) + NEED_W'(rem_reg != '0);

endmodule

`default_nettype wire

// ===== rtl/core/bcba_word_scan.sv =====
// bcba_word_scan: per-word logic at the head of the ring
// applies mark or clear, counts totals and tracks the free run; depends on bcba_pkg
`default_nettype none

module bcba_word_scan (
    input  wire logic [bcba_pkg::WORD_W-1:0] word_in,
    input  wire logic [bcba_pkg::CMP_W-1:0]  base,
    input  wire logic [bcba_pkg::CMP_W-1:0]  lim,
    input  wire logic [bcba_pkg::CMP_W-1:0]  range_lo,
    input  wire logic [bcba_pkg::CMP_W-1:0]  range_hi,
    input  wire logic [bcba_pkg::CMP_W-1:0]  need,
    input  wire bcba_pkg::func_t             func,
    input  wire logic [bcba_pkg::CMP_W-1:0]  run_in,
    output logic      [bcba_pkg::WORD_W-1:0] word_out,
    output bcba_pkg::scan_res_t              res
);
    import bcba_pkg::*;

    always_comb
    begin
        logic [CMP_W-1:0] b;
        logic [CMP_W-1:0] run_j;
        logic [CMP_W-1:0] diff;
        logic             valid;
        logic             in_rng;
        logic             nb;
        logic             free_b;
        logic             all_prev;
        logic             all_cur;
        logic [POP_W-1:0] t_prev;
        logic [POP_W-1:0] t_cur;

        res      = '0;
        word_out = word_in;
        run_j    = run_in;
        all_prev = 1'b1;
        t_prev   = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            b      = base + CMP_W'(j);
            valid  = b < lim;
            in_rng = valid && (b >= range_lo) && (b < range_hi);
            case (func)
                FN_MARK:  nb = in_rng ? 1'b1 : word_in[j];
                FN_CLEAR: nb = in_rng ? 1'b0 : word_in[j];
                default:  nb = word_in[j];
            endcase
            word_out[j] = nb;
            if (valid)
            begin
                if (nb)
                begin
                    res.used_cnt = res.used_cnt + POP_W'(1);
                end
                else
                begin
                    res.free_cnt = res.free_cnt + POP_W'(1);
                end
            end
            // free run ending at this bit, blocks past the limit break it
            free_b  = valid && !word_in[j];
            all_cur = all_prev && free_b;
            t_cur   = free_b ? (t_prev + POP_W'(1)) : '0;
            run_j   = all_cur ? (run_in + CMP_W'(j + 1)) : CMP_W'(t_cur);
            diff    = b + CMP_W'(1) - need;
            if ((func == FN_FIND) && (need != '0) && (run_j >= need) && !res.hit)
            begin
                res.hit       = 1'b1;
                res.hit_start = diff[START_W-1:0];
            end
            all_prev = all_cur;
            t_prev   = t_cur;
        end
        res.run_out = run_j;
    end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_contiguous_block_allocator_unit.sv =====
// bitmap_contiguous_block_allocator_unit: top level of the first-fit block allocator
// instantiates bcba_divider, bcba_cell ring and bcba_word_scan; depends on bcba_pkg
//
// usage
//   s_axis carries one request word: tuser is the request code (find, mark, clear,
//   count), tdata holds byte length and start block. m_axis returns one result word
//   per request: tuser is the found flag, tdata holds run start, block count and the
//   free and used totals as they stand after the request.
//   apb port: block size at address 0, blocks in use at address 4; write only when
//   no request is in flight. pready is tied high.
// timing
//   the result follows the request word through the shift-subtract divider for the block
//   count (20 steps and the done cycle), one pass of the bitmap ring at one 8-bit word per
//   cycle past the scan head, then the load of the output register. one request is worked
//   on at a time; the next is taken in the cycle after the load.
// reset
//   bitmap cleared (all blocks free), block size 16, blocks in use 256, no output.
// back pressure
//   the result sits in the output register until taken; a new request may be
//   accepted meanwhile, and its result waits in the done state if the old one is
//   still held.
`default_nettype none

module bitmap_contiguous_block_allocator_unit #(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // byte_length[19:0], start_block[27:20], zero
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,   // run_start[7:0], block_count[24:8],
                                             // free_count[33:25], used_count[42:34], zero
    output logic      [0:0]  m_axis_tuser,   // found[0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import bcba_pkg::*;

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // configuration registers
    logic [BSZ_W-1:0] block_size_reg;
    logic [BIU_W-1:0] blocks_in_use_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg    <= BSZ_W'(16);
            blocks_in_use_reg <= BIU_W'(256);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_BLOCK_SIZE:    block_size_reg    <= pwdata[BSZ_W-1:0];
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= pwdata[BIU_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BLOCK_SIZE:    prdata = 32'(block_size_reg);
            REG_BLOCKS_IN_USE: prdata = 32'(blocks_in_use_reg);
            default:           prdata = '0;
        endcase
    end

    // managed block count, clipped to the bitmap size
    logic [CMP_W-1:0] lim;
    assign lim = (CMP_W'(blocks_in_use_reg) > CMP_W'(NUM_BLOCKS)) ?
                 CMP_W'(NUM_BLOCKS) : CMP_W'(blocks_in_use_reg);

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   div_done;
    logic   last_word;
    logic   load_out;
    logic   scan_active;

    logic [NEED_W-1:0] div_need;
    logic [WIDX_W-1:0] word_idx_reg;
    logic              m_valid_reg;

    assign last_word = (word_idx_reg == WIDX_W'(NUM_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        scan_active   = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_active = 1'b1;
                if (last_word)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!m_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // block count
    bcba_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (s_axis_tdata[LEN_W-1:0]),
        .divisor  (block_size_reg),
        .done     (div_done),
        .quotient (div_need)
    );

    // request holding registers
    func_t              func_reg;
    logic [START_W-1:0] start_reg;
    logic [CMP_W-1:0]   need_reg;
    logic [CMP_W-1:0]   end_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func_t'(s_axis_tuser);
            start_reg <= s_axis_tdata[LEN_W+START_W-1:LEN_W];
        end
        if (div_done)
        begin
            need_reg <= CMP_W'(div_need);
            end_reg  <= CMP_W'(start_reg) + CMP_W'(div_need);
        end
    end

    // bitmap ring: the head word goes through the scan logic and back in at the tail
    logic [WORD_W-1:0] cell_q [NUM_WORDS];
    logic [WORD_W-1:0] cell_d [NUM_WORDS];
    logic [WORD_W-1:0] scan_word;
    scan_res_t         scan_res;

    for (genvar k = 0; k < NUM_WORDS; k++)
    begin : g_cell
        if (k == NUM_WORDS - 1)
        begin : g_tail
            assign cell_d[k] = scan_word;
        end
        else
        begin : g_link
            assign cell_d[k] = cell_q[k+1];
        end
        bcba_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (scan_active),
            .d     (cell_d[k]),
            .q     (cell_q[k])
        );
    end

    // scan accumulators
    logic [CMP_W-1:0]   run_reg;
    logic               found_reg;
    logic [START_W-1:0] run_start_reg;
    logic [CNT_W-1:0]   free_acc_reg;
    logic [CNT_W-1:0]   used_acc_reg;

    bcba_word_scan u_scan (
        .word_in  (cell_q[0]),
        .base     (CMP_W'(word_idx_reg) << WORD_LOG),
        .lim      (lim),
        .range_lo (CMP_W'(start_reg)),
        .range_hi (end_reg),
        .need     (need_reg),
        .func     (func_reg),
        .run_in   (run_reg),
        .word_out (scan_word),
        .res      (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (accept)
        begin
            word_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (scan_active)
        begin
            word_idx_reg <= last_word ? '0 : (word_idx_reg + WIDX_W'(1));
            if (scan_res.hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_reg      <= '0;
            free_acc_reg <= '0;
            used_acc_reg <= '0;
        end
        else if (scan_active)
        begin
            run_reg      <= scan_res.run_out;
            // totals wrap modulo 512 like the reported field
            free_acc_reg <= free_acc_reg + CNT_W'(scan_res.free_cnt);
            used_acc_reg <= used_acc_reg + CNT_W'(scan_res.used_cnt);
            // first hit only, later words keep counting
            if (scan_res.hit && !found_reg)
            begin
                run_start_reg <= scan_res.hit_start;
            end
        end
    end

    // output register
    logic               out_found_reg;
    logic [START_W-1:0] out_start_reg;
    logic [BC_W-1:0]    out_bc_reg;
    logic [CNT_W-1:0]   out_free_reg;
    logic [CNT_W-1:0]   out_used_reg;
    logic [BC_W-1:0]    bc_sat;

    assign bc_sat = (need_reg > CMP_W'(BC_MAX)) ? BC_MAX[BC_W-1:0] : need_reg[BC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_found_reg <= found_reg;
            out_start_reg <= found_reg ? run_start_reg : '0;
            out_bc_reg    <= (func_reg == FN_COUNT) ? '0 : bc_sat;
            out_free_reg  <= free_acc_reg;
            out_used_reg  <= used_acc_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {5'b0, out_used_reg, out_free_reg, out_bc_reg, out_start_reg};

endmodule

`default_nettype wire

// ===== verif/bitmap_contiguous_block_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// bitmap_contiguous_block_allocator_unit_tb: self-checking bench for the block allocator
// drives request words and apb writes, predicts every result word from its own bitmap copy
// depends on bcba_pkg and bitmap_contiguous_block_allocator_unit

module bitmap_contiguous_block_allocator_unit_tb;

    import bcba_pkg::*;

    localparam int NUM_BLOCKS  = 256;
    localparam int QUIET_LIMIT = 3000;   // cycles with no word moving before giving up
    localparam int PHASE_WORDS = 72;     // random request words per configuration

    // one request word and one result word, as the block sees them
    typedef struct packed {
        func_t               func;
        logic [LEN_W-1:0]    byte_length;
        logic [START_W-1:0]  start_block;
    } alloc_req_t;

    typedef struct packed {
        logic                found;
        logic [START_W-1:0]  run_start;
        logic [BC_W-1:0]     block_count;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    used_count;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // byte_length[19:0], start_block[27:20], zero
    logic [1:0]  s_axis_tuser = '0;     // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // run_start[7:0], block_count[24:8],
                                        // free_count[33:25], used_count[42:34], zero
    logic [0:0]  m_axis_tuser;          // found[0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the allocator: bitmap plus both registers
    bit          used_map [NUM_BLOCKS];
    int unsigned blk_size = 16;
    int unsigned blk_in_use = 256;

    alloc_req_t    pending_requests[$];
    alloc_result_t expected_results[$];

    // knobs the stimulus process turns between phases
    int unsigned send_odds = 3;         // 0 = sender never idles
    int unsigned stall_odds = 3;        // 0 = receiver never stalls
    logic        hold_requests = 1'b0;

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    bitmap_contiguous_block_allocator_unit #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // blocks actually managed: blocks in use clamped to the bitmap size
    function automatic int unsigned managed_count();
        return (blk_in_use > NUM_BLOCKS) ? NUM_BLOCKS : blk_in_use;
    endfunction

    // applies one request to the shadow bitmap and returns the result word it should give
    function automatic alloc_result_t bitmap_step(input alloc_req_t rq);
        alloc_result_t res;
        int unsigned   lim;
        int unsigned   bsz;
        int unsigned   need;
        int unsigned   run;
        int unsigned   idx;
        res = '0;
        lim = managed_count();
        // zero block size acts as one byte per block
        bsz = (blk_size == 0) ? 1 : blk_size;
        need = (rq.byte_length + bsz - 1) / bsz;
        case (rq.func)
            FN_FIND:
            begin
                // first fit: lowest run of need free blocks, zero length never fits
                run = 0;
                if (need != 0)
                begin
                    for (idx = 0; idx < lim; idx++)
                    begin
                        if (!used_map[idx])
                        begin
                            run++;
                            if (run == need)
                            begin
                                res.found = 1'b1;
                                res.run_start = START_W'(idx + 1 - run);
                                break;
                            end
                        end
                        else
                        begin
                            run = 0;
                        end
                    end
                end
            end
            FN_MARK, FN_CLEAR:
            begin
                // range is cut at the managed count
                for (idx = rq.start_block; idx < lim && idx < rq.start_block + need; idx++)
                    used_map[idx] = (rq.func == FN_MARK);
            end
            default:
            begin
            end
        endcase
        // reported count saturates, the full count was used above
        if (rq.func != FN_COUNT)
            res.block_count = BC_W'((need > BC_MAX) ? BC_MAX : need);
        for (idx = 0; idx < lim; idx++)
        begin
            if (used_map[idx])
                res.used_count++;
            else
                res.free_count++;
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns, result word %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic queue_request(input func_t fn, input logic [LEN_W-1:0] len,
                                 input logic [START_W-1:0] start);
        alloc_req_t rq;
        rq.func = fn;
        rq.byte_length = len;
        rq.start_block = start;
        pending_requests.push_back(rq);
    endtask

    // random request shaped around the current block size and managed count
    function automatic alloc_req_t random_request();
        alloc_req_t  rq;
        int unsigned bsz;
        int unsigned lim;
        int unsigned pick;
        int unsigned nblk;
        int unsigned len;
        bsz = (blk_size == 0) ? 1 : blk_size;
        lim = (managed_count() == 0) ? 1 : managed_count();
        pick = $urandom_range(0, 99);
        rq.func = (pick < 35) ? FN_FIND : (pick < 65) ? FN_MARK :
                  (pick < 90) ? FN_CLEAR : FN_COUNT;
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            len = $urandom_range(0, 20'hFFFFF);
        end
        else if (pick == 1)
        begin
            len = 0;
        end
        else
        begin
            // mostly short runs so the bitmap fragments, now and then up to the whole map
            nblk = (pick == 2) ? $urandom_range(1, lim) : $urandom_range(1, (lim < 24) ? lim : 24);
            len = nblk * bsz - $urandom_range(0, bsz - 1);
            if (len > 20'hFFFFF)
                len = 20'hFFFFF;
        end
        rq.byte_length = LEN_W'(len);
        rq.start_block = ($urandom_range(0, 7) == 0) ? START_W'($urandom_range(0, 255))
                                                     : START_W'($urandom_range(0, lim - 1));
        return rq;
    endfunction

    // apb write: setup cycle, access cycle, register taken at the end of access
    task automatic write_config(input logic reg_sel, input int unsigned value);
        int unsigned mask;
        mask = (reg_sel == REG_BLOCK_SIZE) ? 32'h0000_FFFF : 32'h0000_01FF;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        // junk above the register width must be dropped
        pwdata <= ($urandom() & ~mask) | (value & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_sel == REG_BLOCK_SIZE)
            blk_size = value & mask;
        else
            blk_in_use = value & mask;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // idle means nothing queued, nothing offered and no result outstanding
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    // request driver: offers the head of the queue, predicts on acceptance
    always @(posedge clk)
    begin : request_driver
        int unsigned gap_left;
        logic        nxt_valid;
        if (!rst_n)
        begin
            gap_left = 0;
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(bitmap_step(pending_requests.pop_front()));
                nxt_valid = 1'b0;
                // idle burst between words
                if (send_odds != 0 && $urandom_range(0, send_odds) == 0)
                    gap_left = $urandom_range(1, 7);
            end
            // an offered word stays put until taken
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_requests.size() != 0 && !hold_requests)
                begin
                    nxt_valid = 1'b1;
                    s_axis_tuser <= pending_requests[0].func;
                    s_axis_tdata <= {4'b0, pending_requests[0].start_block,
                                     pending_requests[0].byte_length};
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // result monitor: checks each taken word against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        int unsigned   stall_left;
        logic          nxt_ready;
        alloc_result_t got;
        alloc_result_t want;
        if (!rst_n)
        begin
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found = m_axis_tuser[0];
                got.run_start = m_axis_tdata[7:0];
                got.block_count = m_axis_tdata[24:8];
                got.free_count = m_axis_tdata[33:25];
                got.used_count = m_axis_tdata[42:34];
                if (expected_results.size() == 0)
                begin
                    report_error("result word with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                        report_error($sformatf("found %0d, expected %0d",
                                               got.found, want.found));
                    if (got.run_start !== want.run_start)
                        report_error($sformatf("run_start %0d, expected %0d",
                                               got.run_start, want.run_start));
                    if (got.block_count !== want.block_count)
                        report_error($sformatf("block_count %0d, expected %0d",
                                               got.block_count, want.block_count));
                    if (got.free_count !== want.free_count)
                        report_error($sformatf("free_count %0d, expected %0d",
                                               got.free_count, want.free_count));
                    if (got.used_count !== want.used_count)
                        report_error($sformatf("used_count %0d, expected %0d",
                                               got.used_count, want.used_count));
                end
                results_seen++;
            end
            // stall bursts land at any point of the block's work
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(0, 2 * stall_odds) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                nxt_ready = 1'b0;
            end
            else
            begin
                nxt_ready = 1'b1;
            end
            m_axis_tready <= nxt_ready;
        end
    end

    // watchdog: a long stretch with no word moving on any port means a hang
    always @(posedge clk)
    begin : quiet_watchdog
        int unsigned quiet;
        if (!rst_n)
        begin
            quiet = 0;
        end
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || (psel && penable && pwrite))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet == QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", QUIET_LIMIT);
                $display("bitmap_contiguous_block_allocator_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // stimulus: directed words, then random phases under changing configuration
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned k;
        int unsigned bsz;
        int unsigned biu;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: block size 16, all 256 blocks managed and free
        queue_request(FN_COUNT, 20'd12345, 8'd77);        // count reports no block count
        queue_request(FN_FIND, 20'd0, 8'd0);              // zero length never found
        queue_request(FN_FIND, 20'd1, 8'd0);
        queue_request(FN_FIND, 20'd4096, 8'd0);           // exactly the whole map
        queue_request(FN_FIND, 20'd4097, 8'd0);           // one block too many
        queue_request(FN_MARK, 20'd16, 8'd0);
        queue_request(FN_MARK, 20'hFFFFF, 8'd255);        // range runs past the end
        queue_request(FN_FIND, 20'd4064, 8'd0);           // fits between the two ends
        queue_request(FN_FIND, 20'd4065, 8'd0);
        queue_request(FN_MARK, 20'd0, 8'd40);             // zero length changes nothing
        queue_request(FN_CLEAR, 20'd0, 8'd0);
        queue_request(FN_MARK, 20'd33, 8'd100);           // blocks 100 to 102
        queue_request(FN_FIND, 20'd1601, 8'd0);           // first hole too short
        queue_request(FN_CLEAR, 20'hFFFFF, 8'd0);
        wait_for_drain();

        // zero block size acts as one, block count saturates
        write_config(REG_BLOCK_SIZE, 0);
        queue_request(FN_MARK, 20'hFFFFF, 8'd0);
        queue_request(FN_CLEAR, 20'd10, 8'd200);
        queue_request(FN_FIND, 20'd10, 8'd0);
        queue_request(FN_FIND, 20'd11, 8'd0);
        wait_for_drain();

        // nothing managed: never found, totals zero
        write_config(REG_BLOCKS_IN_USE, 0);
        queue_request(FN_FIND, 20'd1, 8'd0);
        queue_request(FN_MARK, 20'd3, 8'd5);
        wait_for_drain();

        // blocks in use above the map size is clamped
        write_config(REG_BLOCKS_IN_USE, 511);
        queue_request(FN_COUNT, 20'hFFFFF, 8'd255);
        wait_for_drain();

        // largest block size
        write_config(REG_BLOCK_SIZE, 65535);
        write_config(REG_BLOCKS_IN_USE, 256);
        queue_request(FN_FIND, 20'hFFFFF, 8'd0);
        queue_request(FN_CLEAR, 20'hFFFFF, 8'd0);
        queue_request(FN_FIND, 20'd65536, 8'd0);
        wait_for_drain();

        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: begin bsz = 16; biu = 256; end
                1: begin bsz = 1; biu = 64; end
                2: begin bsz = 65535; biu = 256; end
                3: begin bsz = $urandom_range(2, 300); biu = $urandom_range(1, 256); end
                4: begin bsz = 7; biu = 8; end
                5: begin bsz = 0; biu = 200; end
                6: begin bsz = 3; biu = 511; end
                7: begin bsz = $urandom_range(1, 65535); biu = 1; end
                default: begin bsz = $urandom_range(1, 64); biu = $urandom_range(129, 256); end
            endcase
            write_config(REG_BLOCK_SIZE, bsz);
            write_config(REG_BLOCKS_IN_USE, biu);
            // vary who idles; the closing phase runs flat out
            @(posedge clk);
            send_odds <= (phase == 8 || phase % 3 == 1) ? 0 : 3;
            stall_odds <= (phase == 8 || phase % 3 == 2) ? 0 : 3;
            for (k = 0; k < PHASE_WORDS; k++)
                pending_requests.push_back(random_request());
            if (phase == 3)
            begin
                // sender holds back until every outstanding result is in
                while (pending_requests.size() > PHASE_WORDS / 2)
                    @(posedge clk);
                hold_requests <= 1'b1;
                @(posedge clk);
                while (expected_results.size() != 0 || s_axis_tvalid)
                    @(posedge clk);
                hold_requests <= 1'b0;
            end
            wait_for_drain();
        end

        // let any stray result word show up before judging
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("bitmap_contiguous_block_allocator_unit_tb OK");
        else
            $display("bitmap_contiguous_block_allocator_unit_tb NOT OK");
        $finish;
    end

endmodule
